// ===== sv/imu7_pkg.sv =====
package imu7_pkg;

  localparam int MaxBytes = 5;
  localparam int CountW = 3;

  localparam logic [6:0] CHAR_AMP = 7'h26;
  localparam logic [6:0] CHAR_DASH = 7'h2d;
  localparam logic [15:0] DIRECT_LO = 16'h0020;
  localparam logic [15:0] DIRECT_HI = 16'h007e;

  typedef struct packed {
    logic [MaxBytes-1:0][6:0] chars;
    logic [CountW-1:0] count;
    logic last;
  } desc_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'h61 + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 7'h30 + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      r = 7'h2b;
    end else begin
      r = 7'h2c;
    end
    return r;
  endfunction

  function automatic logic [6:0] pad_char(input logic [3:0] bits, input logic [2:0] cnt);
    logic [5:0] sym;
    if (cnt == 3'd2) begin
      sym = {bits[1:0], 4'b0000};
    end else begin
      sym = {bits, 2'b00};
    end
    return b64_char(sym);
  endfunction

endpackage

// ===== sv/imap_modified_utf7_encoder.sv =====
// A code unit's bytes are registered in the queue before the first is offered; earlier entries wait ahead.
// The output gives one byte per cycle while byte_stall is low, and an item yields one to five
// bytes; the byte serializer sets the output pace.
// A two-entry queue lets code units be accepted while earlier bytes are still waiting.
// Reset is synchronous and clears the run state, the queue and the byte index.
module imap_modified_utf7_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        unit_valid,
  output logic        unit_stall,
  input  logic [15:0] utf16_unit,
  input  logic        text_end,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [6:0]  out_char,
  output logic        run_end,
  output logic        text_done
);

  logic            push;
  logic            pop;
  logic            full;
  logic            head_valid;
  imu7_pkg::desc_t push_desc;
  imu7_pkg::desc_t head;

  assign unit_stall = full;
  assign push = unit_valid && !full;

  imu7_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .utf16_unit (utf16_unit),
    .text_end   (text_end),
    .desc       (push_desc)
  );

  imu7_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  imu7_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_char   (out_char),
    .run_end    (run_end),
    .text_done  (text_done)
  );

endmodule

// ===== sv/imu7_front.sv =====
module imu7_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [15:0]         utf16_unit,
  input  logic                text_end,
  output imu7_pkg::desc_t     desc
);

  logic       in_shift;
  logic [3:0] spare_bits;
  logic [2:0] spare_count;
  logic       in_shift_next;
  logic [3:0] spare_bits_next;
  logic [2:0] spare_count_next;

  logic [2:0]  n;
  logic        is_direct;
  logic        is_amp;
  logic [3:0]  cur_bits;
  logic [2:0]  cur_cnt;
  logic [19:0] acc;
  logic [3:0]  left_bits;
  logic [2:0]  left_cnt;

  always_comb begin
    desc = '0;
    n = '0;
    in_shift_next = in_shift;
    spare_bits_next = spare_bits;
    spare_count_next = spare_count;
    left_bits = '0;
    left_cnt = '0;
    is_amp = (utf16_unit == {9'd0, imu7_pkg::CHAR_AMP});
    is_direct = (utf16_unit >= imu7_pkg::DIRECT_LO) && (utf16_unit <= imu7_pkg::DIRECT_HI) &&
                !is_amp;
    cur_bits = in_shift ? spare_bits : 4'd0;
    cur_cnt = in_shift ? spare_count : 3'd0;
    acc = {cur_bits, utf16_unit};
    if (is_direct || is_amp) begin
      if (in_shift) begin
        if (spare_count != 3'd0) begin
          desc.chars[n] = imu7_pkg::pad_char(spare_bits, spare_count);
          n = n + 3'd1;
        end
        desc.chars[n] = imu7_pkg::CHAR_DASH;
        n = n + 3'd1;
      end
      in_shift_next = 1'b0;
      spare_bits_next = '0;
      spare_count_next = '0;
      desc.chars[n] = is_amp ? imu7_pkg::CHAR_AMP : utf16_unit[6:0];
      n = n + 3'd1;
      if (is_amp) begin
        desc.chars[n] = imu7_pkg::CHAR_DASH;
        n = n + 3'd1;
      end
    end else begin
      if (!in_shift) begin
        desc.chars[n] = imu7_pkg::CHAR_AMP;
        n = n + 3'd1;
      end
      unique case (cur_cnt)
        3'd2: begin
          desc.chars[n] = imu7_pkg::b64_char(acc[17:12]);
          desc.chars[n + 3'd1] = imu7_pkg::b64_char(acc[11:6]);
          desc.chars[n + 3'd2] = imu7_pkg::b64_char(acc[5:0]);
          n = n + 3'd3;
          left_bits = '0;
          left_cnt = 3'd0;
        end
        3'd4: begin
          desc.chars[n] = imu7_pkg::b64_char(acc[19:14]);
          desc.chars[n + 3'd1] = imu7_pkg::b64_char(acc[13:8]);
          desc.chars[n + 3'd2] = imu7_pkg::b64_char(acc[7:2]);
          n = n + 3'd3;
          left_bits = {2'b00, acc[1:0]};
          left_cnt = 3'd2;
        end
        default: begin
          desc.chars[n] = imu7_pkg::b64_char(acc[15:10]);
          desc.chars[n + 3'd1] = imu7_pkg::b64_char(acc[9:4]);
          n = n + 3'd2;
          left_bits = acc[3:0];
          left_cnt = 3'd4;
        end
      endcase
      if (text_end) begin
        if (left_cnt != 3'd0) begin
          desc.chars[n] = imu7_pkg::pad_char(left_bits, left_cnt);
          n = n + 3'd1;
        end
        desc.chars[n] = imu7_pkg::CHAR_DASH;
        n = n + 3'd1;
        in_shift_next = 1'b0;
        spare_bits_next = '0;
        spare_count_next = '0;
      end else begin
        in_shift_next = 1'b1;
        spare_bits_next = left_bits;
        spare_count_next = left_cnt;
      end
    end
    desc.count = n;
    desc.last = text_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_shift <= 1'b0;
      spare_bits <= '0;
      spare_count <= '0;
    end else if (push) begin
      in_shift <= in_shift_next;
      spare_bits <= spare_bits_next;
      spare_count <= spare_count_next;
    end
  end

endmodule

// ===== sv/imu7_queue.sv =====
module imu7_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  imu7_pkg::desc_t  push_desc,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output imu7_pkg::desc_t  head
);

  logic [1:0]      count;
  imu7_pkg::desc_t slot1;

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        head <= push_desc;
      end else begin
        head <= slot1;
        slot1 <= push_desc;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_desc;
      end else begin
        slot1 <= push_desc;
      end
    end else if (pop) begin
      head <= slot1;
    end
  end

endmodule

// ===== sv/imu7_back.sv =====
module imu7_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  imu7_pkg::desc_t  head,
  output logic             pop,
  output logic             byte_valid,
  input  logic             byte_stall,
  output logic [6:0]       out_char,
  output logic             run_end,
  output logic             text_done
);

  logic [2:0] idx;
  logic       last_byte;

  assign last_byte = (idx + 3'd1 == head.count);
  assign byte_valid = head_valid;
  assign out_char = head.chars[idx];
  assign run_end = last_byte;
  assign text_done = last_byte && head.last;
  assign pop = head_valid && !byte_stall && last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (head_valid && !byte_stall) begin
      idx <= last_byte ? 3'd0 : idx + 3'd1;
    end
  end

endmodule

// ===== test/tb_imap_modified_utf7_encoder.sv =====
module tb_imap_modified_utf7_encoder;

  class utf7_scoreboard;
    typedef struct packed {
      logic [6:0] ch;
      logic       run_end;
      logic       text_done;
    } enc_byte_t;

    enc_byte_t   pending_q[$];
    logic [6:0]  step_chars[$];
    bit          open_run;
    logic [3:0]  held_bits;
    int unsigned held_count;
    int          errors;
    string       alphabet;

    function new();
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+,";
      open_run = 0;
      held_bits = '0;
      held_count = 0;
      errors = 0;
    endfunction

    function logic [6:0] symbol(int unsigned v);
      byte c;
      c = alphabet[v & 6'h3f];
      return c[6:0];
    endfunction

    function void append_char(logic [6:0] c);
      step_chars = {step_chars, c};
    endfunction

    function void close_run();
      if (open_run) begin
        if (held_count != 0) begin
          append_char(symbol((held_bits << (6 - held_count)) & 6'h3f));
        end
        append_char(imu7_pkg::CHAR_DASH);
      end
      open_run = 0;
      held_bits = '0;
      held_count = 0;
    endfunction

    function void note_unit(logic [15:0] u, logic last);
      int unsigned acc;
      int unsigned nbits;
      enc_byte_t   b;
      step_chars.delete();
      if (u >= imu7_pkg::DIRECT_LO && u <= imu7_pkg::DIRECT_HI &&
          u != {9'd0, imu7_pkg::CHAR_AMP}) begin
        close_run();
        append_char(u[6:0]);
      end else if (u == {9'd0, imu7_pkg::CHAR_AMP}) begin
        close_run();
        append_char(imu7_pkg::CHAR_AMP);
        append_char(imu7_pkg::CHAR_DASH);
      end else begin
        if (!open_run) begin
          append_char(imu7_pkg::CHAR_AMP);
          open_run = 1;
          held_bits = '0;
          held_count = 0;
        end
        acc = {12'd0, held_bits, u};
        nbits = held_count + 16;
        while (nbits >= 6) begin
          nbits -= 6;
          append_char(symbol((acc >> nbits) & 6'h3f));
        end
        held_count = nbits;
        held_bits = acc[3:0] & ((4'd1 << nbits) - 4'd1);
        if (last) begin
          close_run();
        end
      end
      foreach (step_chars[i]) begin
        b.ch = step_chars[i];
        b.run_end = (i == step_chars.size() - 1);
        b.text_done = (i == step_chars.size() - 1) && last;
        pending_q = {pending_q, b};
      end
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_byte(logic [6:0] ch, logic re, logic td);
      enc_byte_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected byte %h run_end %b text_done %b", ch, re, td));
      end else begin
        want = pending_q.pop_front();
        if (ch !== want.ch || re !== want.run_end || td !== want.text_done) begin
          report($sformatf("got %h/%b/%b, want %h/%b/%b", ch, re, td,
                           want.ch, want.run_end, want.text_done));
        end
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        unit_valid = 1'b0;
  logic        unit_stall;
  logic [15:0] utf16_unit = '0;
  logic        text_end = 1'b0;
  logic        byte_valid;
  logic        byte_stall = 1'b0;
  logic [6:0]  out_char;
  logic        run_end;
  logic        text_done;

  logic        hold = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  utf7_scoreboard sb = new();

  imap_modified_utf7_encoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .utf16_unit (utf16_unit),
    .text_end   (text_end),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_char   (out_char),
    .run_end    (run_end),
    .text_done  (text_done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_imap_modified_utf7_encoder: errors");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && byte_valid && !byte_stall) begin
        sb.check_byte(out_char, run_end, text_done);
      end
      byte_stall <= hold || ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_unit(input logic [15:0] u, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      unit_valid <= 1'b0;
      @(posedge clk);
    end
    unit_valid <= 1'b1;
    utf16_unit <= u;
    text_end <= last;
    @(posedge clk);
    while (unit_stall) @(posedge clk);
    sb.note_unit(u, last);
  endtask

  task automatic drain();
    unit_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_unit();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 16'($urandom_range(16'h7e, 16'h20));
    if (r < 40) return {9'd0, imu7_pkg::CHAR_AMP};
    if (r < 47) return 16'($urandom_range(16'h1f, 0));
    if (r < 50) return 16'h007f;
    if (r < 55) return 16'($urandom_range(16'hff, 16'h80));
    return 16'($urandom());
  endfunction

  task automatic random_texts(input int n_items);
    int sent;
    int len;
    logic last;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        if (i == len - 1) last = ($urandom_range(9) != 0);
        else last = ($urandom_range(19) == 0);
        send_unit(pick_unit(), last);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_unit(16'h0020, 1'b0);
    send_unit(16'h007e, 1'b0);
    send_unit({9'd0, imu7_pkg::CHAR_AMP}, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hffff, 1'b1);
    send_unit(16'h001f, 1'b0);
    send_unit(16'h007f, 1'b0);
    send_unit(16'h8000, 1'b1);
    send_unit(16'h5555, 1'b0);
    send_unit(16'haaaa, 1'b0);
    send_unit(16'hd800, 1'b0);
    send_unit(16'hdc00, 1'b1);
    send_unit(16'h00e9, 1'b0);
    send_unit({9'd0, imu7_pkg::CHAR_AMP}, 1'b0);
    send_unit(16'h4e2d, 1'b0);
    send_unit(16'h0061, 1'b1);
    send_unit(16'h0100, 1'b0);
    send_unit({9'd0, imu7_pkg::CHAR_AMP}, 1'b1);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h00ff, 1'b0);
    send_unit(16'h0001, 1'b0);
    send_unit(16'h002d, 1'b1);
    send_unit(16'h007a, 1'b1);
    drain();

    random_texts(20);
    fork
      begin
        hold <= 1'b1;
        repeat (200) @(posedge clk);
        hold <= 1'b0;
      end
    join_none
    random_texts(40);
    drain();

    send_idle_pct = 59;
    random_texts(55);
    drain();

    send_idle_pct = 0;
    stall_pct = 59;
    random_texts(55);
    drain();

    send_idle_pct = 6;
    stall_pct = 6;
    random_texts(55);
    drain();

    repeat (20) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      sb.report($sformatf("%0d expected bytes never arrived", sb.pending_q.size()));
    end
    if (sb.errors == 0) begin
      $display("tb_imap_modified_utf7_encoder: clean");
    end else begin
      $display("tb_imap_modified_utf7_encoder: errors");
    end
    $finish;
  end

endmodule
